// File: rtl/core/assert_macros.svh
// Assertion macros shared by the sliding anagram window matcher.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SAWM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SAWM_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sawm_pkg.sv
// Types and constants of the sliding anagram window matcher.
// No dependencies; used by every module of the block.
package sawm_pkg;

   localparam int LETTER_W    = 5;
   localparam int CMD_W       = 2;
   localparam int POS_W       = 16;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_PATTERN,
      OP_TEXT,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LETTER_W-1:0]  letter;
      logic                 in_alpha;
   } entry_type;

   // found sits in the lowest bit
   typedef struct packed {
      logic                 pattern_full;
      logic [POS_W-1:0]     end_pos;
      logic [POS_W-1:0]     start_pos;
      logic                 found;
   } result_type;

endpackage

// File: rtl/core/sliding_anagram_window_matcher_top.sv
// Sliding anagram window matcher: requests pass the command queue, back end and result queue.
// One request item per cycle is taken while there is room; rsp stalls fill the two-entry queues.
// The match test for each text letter uses per-letter equality flags and a single AND.
// Reset is synchronous: counts, pattern length, positions and queues clear at once.
// The letter ring needs no clearing pass; only slots written for the live window are read.
module sliding_anagram_window_matcher_top #(
   parameter int ALPHABET_SIZE = 26,
   parameter int MAX_PATTERN   = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sawm_pkg::REQ_TDATA_W-1:0]  req_tdata,  // letter[4:0], zero pad
   input  logic [sawm_pkg::CMD_W-1:0]        req_tuser,  // cmd[1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sawm_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // found, start_pos, end_pos,
                                                         // pattern_full, zero pad
);
   import sawm_pkg::*;

   entry_type                  fr_ent, bk_ent;
   logic                       fr_valid, fr_ready;
   logic                       q_valid, q_ready;
   logic [$bits(entry_type)-1:0]  q_data;
   result_type                 bk_res;
   logic                       bk_valid, bk_ready;
   logic [$bits(result_type)-1:0] out_data;

   sawm_front #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ent_valid  (fr_valid),
      .ent_ready  (fr_ready),
      .ent        (fr_ent)
   );

   sawm_fifo #(
      .WIDTH ($bits(entry_type))
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_ent),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign bk_ent = entry_type'(q_data);

   sawm_back #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .MAX_PATTERN   (MAX_PATTERN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (q_valid),
      .ent_ready (q_ready),
      .ent       (bk_ent),
      .res_valid (bk_valid),
      .res_ready (bk_ready),
      .res       (bk_res)
   );

   sawm_fifo #(
      .WIDTH ($bits(result_type))
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (bk_valid),
      .push_ready (bk_ready),
      .push_data  (bk_res),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (out_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(out_data);

endmodule

// File: rtl/core/sawm_fifo.sv
// Short first-in first-out queue of fixed depth.
// Depends on sawm_pkg for the depth.
module sawm_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import sawm_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != NW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/sawm_front.sv
// Front end: takes request items and classifies them into queue entries.
// Depends on sawm_pkg for command codes and the entry type.
module sawm_front #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sawm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [sawm_pkg::CMD_W-1:0]        req_tuser,
   output logic                              ent_valid,
   input  logic                              ent_ready,
   output sawm_pkg::entry_type               ent
);
   import sawm_pkg::*;

   logic [LETTER_W-1:0] letter;

   assign letter     = req_tdata[LETTER_W-1:0];
   assign ent_valid  = req_tvalid;
   assign req_tready = ent_ready;

   always_comb begin
      ent.letter   = letter;
      ent.in_alpha = (32'(letter) < ALPHABET_SIZE);
      case (req_tuser)
         CMD_CLEAR:   ent.op = OP_CLEAR;
         CMD_PATTERN: ent.op = OP_PATTERN;
         CMD_TEXT:    ent.op = OP_TEXT;
         default:     ent.op = OP_NONE;
      endcase
   end

endmodule

// File: rtl/core/sawm_back.sv
// Back end: pattern and window histograms, letter ring and match decision.
// Depends on sawm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sawm_back #(
   parameter int ALPHABET_SIZE = 26,
   parameter int MAX_PATTERN   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ent_valid,
   output logic                  ent_ready,
   input  sawm_pkg::entry_type   ent,
   output logic                  res_valid,
   input  logic                  res_ready,
   output sawm_pkg::result_type  res
);
   import sawm_pkg::*;

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [CW-1:0]       pc_ff [ALPHABET_SIZE];
   logic [CW-1:0]       pc_in [ALPHABET_SIZE];
   logic [CW-1:0]       pc_nx [ALPHABET_SIZE];
   logic [CW-1:0]       wc_ff [ALPHABET_SIZE];
   logic [CW-1:0]       wc_in [ALPHABET_SIZE];
   logic [CW-1:0]       wc_mid [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] eq_ff, eq_in, eq_chk, mid_eq, hit, ohit, dec;
   logic [CW-1:0]       plen_ff, plen_in;
   logic [CW-1:0]       fill_ff, fill_in, fill1;
   logic [POS_W-1:0]    tpos_ff, tpos_in;
   logic [POS_W-1:0]    wstart_ff, wstart_in;
   logic [RW-1:0]       head_ff, head_in, head_nx;
   logic [RW-1:0]       tail_ff, tail_in, tail_nx;
   logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
   logic [LETTER_W-1:0] oldest_ff, old_letter;
   logic step, is_clr, is_pat, is_txt, pat_full, pat_add, txt_ok, txt_bad;
   logic match, drop, wipe;

   assign step      = ent_valid && res_ready;
   assign ent_ready = res_ready;
   assign res_valid = ent_valid;

   assign is_clr   = step && (ent.op == OP_CLEAR);
   assign is_pat   = step && (ent.op == OP_PATTERN);
   assign is_txt   = step && (ent.op == OP_TEXT);
   assign pat_full = (plen_ff >= CW'(MAX_PATTERN));
   assign pat_add  = is_pat && !pat_full && ent.in_alpha;
   assign txt_ok   = is_txt && ent.in_alpha;
   assign txt_bad  = is_txt && !ent.in_alpha;
   assign fill1    = fill_ff + 1'b1;

   assign match      = txt_ok && (fill1 == plen_ff) && (&mid_eq);
   assign drop       = txt_ok && !match && (fill1 >= plen_ff);
   assign wipe       = is_clr || txt_bad || match;
   assign old_letter = (fill_ff == '0) ? ent.letter : oldest_ff;

   for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_lane
      assign hit[i]    = (32'(ent.letter) == i);
      assign ohit[i]   = (32'(old_letter) == i);
      assign pc_nx[i]  = pc_ff[i] + CW'(pat_add && hit[i]);
      assign wc_mid[i] = wc_ff[i] + CW'(txt_ok && hit[i]);
      assign mid_eq[i] = (txt_ok && hit[i]) ? (wc_mid[i] == pc_ff[i]) : eq_ff[i];
      assign dec[i]    = drop && ohit[i] && (wc_mid[i] != '0);
      assign wc_in[i]  = wipe ? '0 : wc_mid[i] - CW'(dec[i]);
      assign pc_in[i]  = is_clr ? '0 : pc_nx[i];
      assign eq_in[i]  = (wc_in[i] == pc_in[i]);
      assign eq_chk[i] = (wc_ff[i] == pc_ff[i]);
   end

   always_comb begin
      head_nx = (head_ff == RW'(MAX_PATTERN - 1)) ? '0 : head_ff + 1'b1;
      tail_nx = (tail_ff == RW'(MAX_PATTERN - 1)) ? '0 : tail_ff + 1'b1;

      plen_in = is_clr ? '0 : (pat_add ? plen_ff + 1'b1 : plen_ff);
      tpos_in = is_clr ? '0 : (is_txt ? tpos_ff + 1'b1 : tpos_ff);
      head_in = is_clr ? '0 : (txt_ok ? head_nx : head_ff);

      if (wipe) begin
         fill_in = '0;
      end else if (txt_ok && !drop) begin
         fill_in = fill1;
      end else begin
         fill_in = fill_ff;
      end

      if (is_clr) begin
         wstart_in = '0;
         tail_in   = '0;
      end else if (txt_bad || match) begin
         wstart_in = tpos_ff + 1'b1;
         tail_in   = head_in;
      end else if (drop) begin
         wstart_in = wstart_ff + 1'b1;
         tail_in   = tail_nx;
      end else begin
         wstart_in = wstart_ff;
         tail_in   = tail_ff;
      end

      res.found        = match;
      res.start_pos    = match ? wstart_ff : '0;
      res.end_pos      = match ? tpos_ff : '0;
      res.pattern_full = is_pat && pat_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            pc_ff[i] <= '0;
            wc_ff[i] <= '0;
         end
         eq_ff     <= '1;
         plen_ff   <= '0;
         fill_ff   <= '0;
         tpos_ff   <= '0;
         wstart_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
      end else begin
         for (int i = 0; i < ALPHABET_SIZE; i++) begin
            pc_ff[i] <= pc_in[i];
            wc_ff[i] <= wc_in[i];
         end
         eq_ff     <= eq_in;
         plen_ff   <= plen_in;
         fill_ff   <= fill_in;
         tpos_ff   <= tpos_in;
         wstart_ff <= wstart_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
   end

   // hold the oldest window letter ready for the next item
   always_ff @(posedge clock) begin
      if (txt_ok) begin
         ring_mem[head_ff] <= ent.letter;
      end
      if (txt_ok && (tail_in == head_ff)) begin
         oldest_ff <= ent.letter;
      end else begin
         oldest_ff <= ring_mem[tail_in];
      end
   end

   `SAWM_ASSERT(a_fill_below_len, (fill_ff == '0) || (fill_ff < plen_ff), "window overfull")
   `SAWM_ASSERT(a_pos_span, POS_W'(wstart_ff + POS_W'(fill_ff)) == tpos_ff, "window span lost")
   `SAWM_ASSERT(a_eq_flags, eq_ff == eq_chk, "equality flags out of step with counts")
   `SAWM_ASSERT(a_clear_empties, is_clr |=> (plen_ff == '0) && (fill_ff == '0), "clear missed")
   `SAWM_ASSERT_IMP(a_found_span, match, POS_W'(tpos_ff - wstart_ff) == POS_W'(plen_ff - 1'b1), "match span wrong")

endmodule

// File: tb/tb.sv
// Self-checking bench for sliding_anagram_window_matcher_top: a directed table, then random
// pattern and text runs, checked against typed rows or a behavioural matcher in this file.
// Depends on sawm_pkg and the top level only.
`timescale 1ns / 100ps

module tb;
   import sawm_pkg::*;

   localparam int ALPHA        = 26;
   localparam int MAX_PAT      = 64;
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 1000;
   localparam int LONG_HOLD    = 80;
   localparam int HOLD_AT      = 500;
   localparam int PRINT_LIMIT  = 20;

   localparam logic [CMD_W-1:0] CMD_UNUSED = OP_NONE;

   localparam result_type NO_MATCH  = '0;
   localparam result_type FULL_FLAG = '{pattern_full: 1'b1, default: '0};

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [LETTER_W-1:0] letter;
      int unsigned         reps;
      bit                  typed;
      result_type          want;
   } stim_type;

   localparam stim_type DIRECTED [0:26] = '{
      '{CMD_TEXT,    5'd0,  1,     1'b1, NO_MATCH},
      '{CMD_UNUSED,  5'd31, 1,     1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd0,  1,     1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd1,  1,     1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd31, 1,     1'b1, NO_MATCH},
      '{CMD_TEXT,    5'd1,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd0,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd25, 1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd27, 1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd0,  1,     1'b0, NO_MATCH},
      '{CMD_PATTERN, 5'd2,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd2,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd1,  1,     1'b0, NO_MATCH},
      '{CMD_CLEAR,   5'd0,  1,     1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd0,  64,    1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd25, 1,     1'b1, FULL_FLAG},
      '{CMD_PATTERN, 5'd31, 1,     1'b1, FULL_FLAG},
      '{CMD_TEXT,    5'd0,  63,    1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd0,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd30, 1,     1'b0, NO_MATCH},
      '{CMD_CLEAR,   5'd31, 1,     1'b1, NO_MATCH},
      '{CMD_PATTERN, 5'd0,  1,     1'b0, NO_MATCH},
      '{CMD_PATTERN, 5'd1,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd2,  40,    1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd0,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd1,  1,     1'b0, NO_MATCH},
      '{CMD_TEXT,    5'd16, 1,     1'b0, NO_MATCH}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // matcher state
   int unsigned         pattern_hist [ALPHA];
   int unsigned         window_hist  [ALPHA];
   logic [LETTER_W-1:0] window_ring  [MAX_PAT];
   int unsigned         pattern_len;
   int unsigned         window_fill;
   int unsigned         ring_head;
   logic [POS_W-1:0]    text_pos;
   logic [POS_W-1:0]    window_start;

   result_type expected_results [$];
   int         mismatches    = 0;
   int         items_sent    = 0;
   int         live_items    = 0;
   int         results_seen  = 0;
   int         matches_seen  = 0;
   int         full_seen     = 0;
   int         idle_cycles   = 0;
   bit         send_calm     = 1'b0;
   bit         recv_calm     = 1'b0;

   sliding_anagram_window_matcher_top #(
      .ALPHABET_SIZE(ALPHA),
      .MAX_PATTERN  (MAX_PAT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_window(input logic [POS_W-1:0] next_start);
      foreach (window_hist[i]) window_hist[i] = 0;
      window_fill  = 0;
      window_start = next_start;
   endfunction

   function automatic void clear_matcher();
      foreach (pattern_hist[i]) pattern_hist[i] = 0;
      restart_window('0);
      pattern_len = 0;
      ring_head   = 0;
      text_pos    = '0;
   endfunction

   function automatic result_type predict_match(input logic [CMD_W-1:0] cmd,
                                                input logic [LETTER_W-1:0] letter);
      result_type       r;
      logic [POS_W-1:0] pos;
      bit               hit;
      int unsigned      idx;
      r = NO_MATCH;
      case (cmd)
         CMD_CLEAR: clear_matcher();
         CMD_PATTERN: begin
            if (pattern_len >= MAX_PAT) begin
               r.pattern_full = 1'b1;
            end else if (letter < ALPHA) begin
               pattern_hist[letter]++;
               pattern_len++;
            end
         end
         CMD_TEXT: begin
            pos      = text_pos;
            text_pos = text_pos + 1'b1;
            if (letter >= ALPHA) begin
               restart_window(pos + 1'b1);
            end else begin
               window_hist[letter]++;
               window_ring[ring_head] = letter;
               ring_head = (ring_head + 1) % MAX_PAT;
               window_fill++;
               hit = (window_fill == pattern_len);
               for (int i = 0; i < ALPHA; i++)
                  if (window_hist[i] != pattern_hist[i]) hit = 1'b0;
               if (hit) begin
                  r.found     = 1'b1;
                  r.start_pos = window_start;
                  r.end_pos   = pos;
                  restart_window(pos + 1'b1);
               end else if (window_fill >= pattern_len) begin
                  idx = (ring_head + MAX_PAT - (window_fill % MAX_PAT)) % MAX_PAT;
                  if (window_ring[idx] < ALPHA && window_hist[window_ring[idx]] > 0)
                     window_hist[window_ring[idx]]--;
                  window_fill--;
                  window_start = window_start + 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] result item %0d: %s", $realtime, results_seen, msg);
   endtask

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter,
                            input bit typed, input result_type want);
      int         gap;
      result_type r;
      gap = send_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_TDATA_W'(letter);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_match(cmd, letter);
      expected_results.insert(expected_results.size(), typed ? want : r);
      items_sent++;
      if (cmd != CMD_UNUSED) live_items++;
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      @(negedge clock);
   endtask

   task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter);
      send_item(cmd, letter, 1'b0, NO_MATCH);
   endtask

   // stimulus
   initial begin
      int  len;
      int  span;
      int  base;
      int  n;
      int  pick;
      bit  drained;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      drained    = 1'b0;
      clear_matcher();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[row])
         repeat (DIRECTED[row].reps)
            send_item(DIRECTED[row].cmd, DIRECTED[row].letter, DIRECTED[row].typed,
                      DIRECTED[row].want);

      live_items = 0;
      while (live_items < RANDOM_ITEMS) begin
         if (!drained && live_items >= RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (expected_results.size() != 0);
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_random(CMD_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)));
         end else begin
            if ($urandom_range(0, 4) != 0) send_random(CMD_CLEAR, LETTER_W'($urandom_range(0, 31)));
            len  = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            span = $urandom_range(2, 5);
            base = $urandom_range(0, ALPHA - span);
            repeat (len) begin
               if ($urandom_range(0, 19) == 0)
                  send_random(CMD_PATTERN, LETTER_W'($urandom_range(ALPHA, 31)));
               else
                  send_random(CMD_PATTERN, LETTER_W'(base + $urandom_range(0, span - 1)));
            end
            n = len + $urandom_range(10, 60);
            repeat (n) begin
               pick = $urandom_range(0, 119);
               if (pick < 4)
                  send_random(CMD_TEXT, LETTER_W'($urandom_range(ALPHA, 31)));
               else if (pick < 7)
                  send_random(CMD_PATTERN, LETTER_W'(base + $urandom_range(0, span - 1)));
               else if (pick < 9)
                  send_random(CMD_UNUSED, LETTER_W'($urandom_range(0, 31)));
               else
                  send_random(CMD_TEXT, LETTER_W'(base + $urandom_range(0, span - 1)));
            end
         end
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d request items and %0d result items: %0d matches, %0d full flags",
               items_sent, results_seen, matches_seen, full_seen);
      $display("directed corners, a long result stall and a full drain included");
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("sliding_anagram_window_matcher_top regression: pass");
      end else begin
         $display("sliding_anagram_window_matcher_top regression: fail");
      end
      $finish;
   end

   // result side
   initial begin
      int         gap;
      result_type got;
      result_type want;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = recv_calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = rsp_tdata[$bits(result_type)-1:0];
         if (expected_results.size() == 0) begin
            report_mismatch("item with no expectation waiting");
         end else begin
            want = expected_results.pop_front();
            if (got.found !== want.found)
               report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
            if (got.start_pos !== want.start_pos)
               report_mismatch($sformatf("start_pos %0d, want %0d", got.start_pos,
                                         want.start_pos));
            if (got.end_pos !== want.end_pos)
               report_mismatch($sformatf("end_pos %0d, want %0d", got.end_pos, want.end_pos));
            if (got.pattern_full !== want.pattern_full)
               report_mismatch($sformatf("pattern_full %0b, want %0b", got.pattern_full,
                                         want.pattern_full));
         end
         results_seen++;
         if (got.found === 1'b1) matches_seen++;
         if (got.pattern_full === 1'b1) full_seen++;
         if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
         @(negedge clock);
         // hold off long enough for the block to back up onto its input
         if (results_seen == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("sliding_anagram_window_matcher_top regression: fail");
         $finish;
      end
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sawm_pkg.sv
rtl/core/sawm_fifo.sv
rtl/core/sawm_front.sv
rtl/core/sawm_back.sv
rtl/core/sliding_anagram_window_matcher_top.sv
tb/tb.sv
